>>> hw/rtl/lesf_pkg.sv
// ----------------------------------------------------------------------------
// lesf_pkg
// Shared widths, constants and types of the largest empty square finder.
// ----------------------------------------------------------------------------
package lesf_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int SIZE_W = 11;
    localparam int DIM_W  = 11;
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 1;

    localparam logic [CHAR_W-1:0] FREE_CHAR = 8'h2E;

    localparam logic [ADDR_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [ADDR_W-1:0] REG_GRID_COLS = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } square_t;

    typedef struct packed {
        logic    valid;
        square_t square;
    } result_push_t;

    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } outbuf_status_t;

endpackage

>>> hw/rtl/lesf_line_ram.sv
// ----------------------------------------------------------------------------
// lesf_line_ram
// Line store of square sizes of the row above, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module lesf_line_ram
    import lesf_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [COL_W-1:0]  waddr,
    input  logic [SIZE_W-1:0] wdata,
    input  logic              re,
    input  logic [COL_W-1:0]  raddr,
    output logic [SIZE_W-1:0] rdata
);

    logic [SIZE_W-1:0] mem [MAX_COLS];
    logic [SIZE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/lesf_scan.sv
// ----------------------------------------------------------------------------
// lesf_scan
// Grid position counters, line store access and the dynamic-programming
// update of square sizes with best square tracking.
// ----------------------------------------------------------------------------
module lesf_scan
    import lesf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [DIM_W-1:0]  cfg_wdata,
    input  logic              accept,
    input  logic [CHAR_W-1:0] cell_char,
    output result_push_t      res
);

    logic [DIM_W-1:0]  rows_cfg_reg;
    logic [DIM_W-1:0]  cols_cfg_reg;
    logic [DIM_W-1:0]  rows_lim;
    logic [DIM_W-1:0]  cols_lim;

    logic [COL_W-1:0]  col_count_reg;
    logic [COL_W-1:0]  col_count_next;
    logic [ROW_W-1:0]  row_count_reg;
    logic [ROW_W-1:0]  row_count_next;
    logic              row_end;
    logic              grid_end;

    logic              s1_valid_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_free_reg;
    logic              s1_end_reg;

    logic              fwd_hit_reg;
    logic              fwd_hit_next;
    logic [SIZE_W-1:0] fwd_size_reg;

    logic [COL_W:0]    filled_reg;
    logic              up_known_reg;
    logic              up_known_next;

    logic [SIZE_W-1:0] left_reg;
    logic [SIZE_W-1:0] diag_reg;
    square_t           best_reg;
    square_t           best_next;

    logic [SIZE_W-1:0] rdata;
    logic [SIZE_W-1:0] up;
    logic [SIZE_W-1:0] lf;
    logic [SIZE_W-1:0] dg;
    logic [SIZE_W-1:0] min_ul;
    logic [SIZE_W-1:0] min_all;
    logic [SIZE_W-1:0] sz;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= DIM_W'(1);
            cols_cfg_reg <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_GRID_ROWS: rows_cfg_reg <= cfg_wdata;
                REG_GRID_COLS: cols_cfg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (rows_cfg_reg == '0)
            rows_lim = DIM_W'(1);
        else if (rows_cfg_reg > DIM_W'(MAX_ROWS))
            rows_lim = DIM_W'(MAX_ROWS);
        else
            rows_lim = rows_cfg_reg;

        if (cols_cfg_reg == '0)
            cols_lim = DIM_W'(1);
        else if (cols_cfg_reg > DIM_W'(MAX_COLS))
            cols_lim = DIM_W'(MAX_COLS);
        else
            cols_lim = cols_cfg_reg;
    end

    // position of the next item
    always_comb
    begin
        row_end  = (DIM_W'(col_count_reg) + DIM_W'(1)) >= cols_lim;
        grid_end = row_end && ((DIM_W'(row_count_reg) + DIM_W'(1)) >= rows_lim);
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (grid_end)
            begin
                col_count_next = '0;
                row_count_next = '0;
            end
            else if (row_end)
            begin
                col_count_next = '0;
                row_count_next = row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
        fwd_hit_next  = accept && s1_valid_reg && (s1_col_reg == col_count_reg);
        up_known_next = ({1'b0, col_count_reg} < filled_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= accept;
            fwd_hit_reg   <= fwd_hit_next;
        end
    end

    // columns written since reset, always a prefix of the line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
        end
        else if (s1_valid_reg && ({1'b0, s1_col_reg} == filled_reg))
        begin
            filled_reg <= filled_reg + (COL_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg   <= row_count_reg;
            s1_col_reg   <= col_count_reg;
            s1_free_reg  <= (cell_char == FREE_CHAR);
            s1_end_reg   <= grid_end;
            fwd_size_reg <= sz;
            up_known_reg <= up_known_next;
        end
    end

    lesf_line_ram u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (sz),
        .re    (accept),
        .raddr (col_count_reg),
        .rdata (rdata)
    );

    // size update, min of three plus one for a free cell, zero otherwise
    always_comb
    begin
        if (s1_row_reg == '0)
            up = '0;
        else if (fwd_hit_reg)
            up = fwd_size_reg;
        else if (up_known_reg)
            up = rdata;
        else
            up = '0;
        lf      = (s1_col_reg == '0) ? '0 : left_reg;
        dg      = (s1_row_reg == '0 || s1_col_reg == '0) ? '0 : diag_reg;
        min_ul  = (up < lf) ? up : lf;
        min_all = (min_ul < dg) ? min_ul : dg;
        sz      = s1_free_reg ? (min_all + SIZE_W'(1)) : '0;

        best_next = best_reg;
        if (sz > best_reg.size)
        begin
            best_next.size = sz;
            best_next.row  = s1_row_reg + ROW_W'(1) - sz[ROW_W-1:0];
            best_next.col  = s1_col_reg + COL_W'(1) - sz[COL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            left_reg <= sz;
            diag_reg <= up;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            best_reg <= s1_end_reg ? '0 : best_next;
        end
    end

    assign res.valid  = s1_valid_reg && s1_end_reg;
    assign res.square = best_next;

endmodule

>>> hw/rtl/lesf_out_buf.sv
// ----------------------------------------------------------------------------
// lesf_out_buf
// Two-entry result queue between the scan pipeline and the output channel.
// ----------------------------------------------------------------------------
module lesf_out_buf
    import lesf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  result_push_t   push,
    input  logic           out_ready,
    output logic           out_valid,
    output square_t        out_square,
    output outbuf_status_t status
);

    square_t    slot_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       pop;

    assign out_valid  = (count_reg != 2'd0);
    assign out_square = slot_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
            count_next = count_reg + 2'd1;
        else if (!push.valid && pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push.valid)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.square;
        end
    end

    assign status.count = count_reg;
    assign status.pop   = pop;

endmodule

>>> hw/rtl/largest_empty_square_finder.sv
// ----------------------------------------------------------------------------
// largest_empty_square_finder
// Finds the largest square of free map cells in a streamed grid.
// ----------------------------------------------------------------------------
// Map characters arrive one per item on the in channel (in_valid/in_ready),
// row-major; '.' is a free cell. The grid size comes from the grid_rows and
// grid_cols registers, written through cfg_we/cfg_addr/cfg_wdata while idle.
// After the last cell of a grid one item leaves on the out channel
// (out_valid/out_ready): square size, top row and left column of the first
// largest free square, size 0 when there is none.
// Throughput is one cell per cycle while in_ready is high, set by the
// read-modify-write of the line store (one read and one write port,
// forwarding on a repeat of the same column). out_valid rises once the last
// cell of a grid has passed the scan stage registers and been written to the
// result queue. Results queue in a two-entry buffer; while the receiver
// stalls, in_ready drops as soon as two results are queued or in flight, so
// one-cell grids run at one cell per cycle only while out_ready stays high.
// Reset sets both grid dimensions to 1 and starts a new grid; the line store
// needs no clearing pass, a fill count makes entries not yet written since
// reset read as zero.
// ----------------------------------------------------------------------------
module largest_empty_square_finder
    import lesf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [DIM_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] cell_char,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SIZE_W-1:0] square_size,
    output logic [ROW_W-1:0]  top_row,
    output logic [COL_W-1:0]  left_col
);

    result_push_t   res;
    outbuf_status_t buf_status;
    square_t        out_square;
    logic           accept;
    logic [2:0]     fill;
    logic [2:0]     room;

    // space for an item's result: queued plus in flight, less what leaves now
    assign fill     = 3'(buf_status.count) + 3'(res.valid);
    assign room     = 3'd1 + 3'(buf_status.pop);
    assign in_ready = (fill <= room);
    assign accept   = in_valid && in_ready;

    lesf_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .cell_char (cell_char),
        .res       (res)
    );

    lesf_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_square (out_square),
        .status     (buf_status)
    );

    assign square_size = out_square.size;
    assign top_row     = out_square.row;
    assign left_col    = out_square.col;

endmodule

>>> hw/rtl/lesf_checker.sv
// ----------------------------------------------------------------------------
// lesf_checker
// Port-level checks of the largest empty square finder results.
// ----------------------------------------------------------------------------
module lesf_checker
    import lesf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [SIZE_W-1:0] square_size,
    input logic [ROW_W-1:0]  top_row,
    input logic [COL_W-1:0]  left_col
);

    // stalled item stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(square_size)
            && $stable(top_row) && $stable(left_col))
        else $error("stalled out item changed");

    // empty grid reports the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (square_size == '0) |-> (top_row == '0) && (left_col == '0))
        else $error("zero size with nonzero corner");

    // square fits the column range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (12'(left_col) + 12'(square_size)) <= 12'(MAX_COLS))
        else $error("square exceeds columns");

endmodule

bind largest_empty_square_finder lesf_checker u_lesf_checker (.*);
